// ===== rtl/bresenham_line_stepper_assert.svh =====
// ----------------------------------------------------------------------------
// bresenham line stepper assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_STEPPER_ASSERT_SVH
`define BRESENHAM_LINE_STEPPER_ASSERT_SVH

// next-cycle implication, off while reset is asserted
`define BLS_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("bls: port check failed");

// next-cycle implication that also runs through reset
`define BLS_ASSERT_RESET(lbl, clk, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("bls: reset check failed");

`endif

// ===== rtl/bls_pkg.sv =====
// ----------------------------------------------------------------------------
// bls_pkg
// opcodes, octant rule codes and queue status shared by the line stepper
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bls_pkg;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic [1:0] MODE_X_UP   = 2'd0;
  localparam logic [1:0] MODE_X_DOWN = 2'd1;
  localparam logic [1:0] MODE_Y_UP   = 2'd2;
  localparam logic [1:0] MODE_Y_DOWN = 2'd3;

  localparam int QDEPTH = 2;

  typedef struct packed {
    logic can_push;
    logic has_data;
  } bls_qstat_t;

endpackage

// ===== rtl/bresenham_line_stepper.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_stepper
// a step word passes stage a, stage b and the queue, then its pixel is registered
// throughput: one word per cycle while out_stall is low, set by the pixel step loop
// reset: synchronous active-low rst_n empties the pipe and leaves no line active
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bresenham_line_stepper #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_opcode,
  input  logic [COORD_BITS-1:0] in_start_x,
  input  logic [COORD_BITS-1:0] in_start_y,
  input  logic [COORD_BITS-1:0] in_end_x,
  input  logic [COORD_BITS-1:0] in_end_y,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] out_pixel_x,
  output logic [COORD_BITS-1:0] out_pixel_y,
  output logic                  out_final_pixel
);
  import bls_pkg::*;

  localparam int ENTRY_W = 6 * COORD_BITS + 10;

  bls_qstat_t         q_stat;
  logic               q_push, q_pop;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;

  bls_front #(
    .COORD_BITS (COORD_BITS),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_opcode  (in_opcode),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_end_x   (in_end_x),
    .in_end_y   (in_end_y),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  bls_queue #(
    .ENTRY_W (ENTRY_W)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  bls_back #(
    .COORD_BITS (COORD_BITS),
    .ENTRY_W    (ENTRY_W)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .q_rdata         (q_rdata),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_final_pixel (out_final_pixel)
  );

endmodule

// ===== rtl/bls_queue.sv =====
// ----------------------------------------------------------------------------
// bls_queue
// short register queue between the setup front and the stepping back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bls_queue #(
  parameter int ENTRY_W = 82
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [ENTRY_W-1:0] wdata,
  input  logic               pop,
  output logic [ENTRY_W-1:0] rdata,
  output bls_pkg::bls_qstat_t stat
);
  import bls_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  logic [ENTRY_W-1:0] mem_r [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata         = mem_r[rd_ptr_r];
  assign stat.can_push = (count_r != CNT_W'(QDEPTH));
  assign stat.has_data = (count_r != '0);

endmodule

// ===== rtl/bls_front.sv =====
// ----------------------------------------------------------------------------
// bls_front
// accepts words, measures the endpoints and sets up the octant rule
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bls_front #(
  parameter int COORD_BITS = 12,
  parameter int ENTRY_W    = 6 * COORD_BITS + 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_opcode,
  input  logic [COORD_BITS-1:0] in_start_x,
  input  logic [COORD_BITS-1:0] in_start_y,
  input  logic [COORD_BITS-1:0] in_end_x,
  input  logic [COORD_BITS-1:0] in_end_y,
  input  bls_pkg::bls_qstat_t   q_stat,
  output logic                  q_push,
  output logic [ENTRY_W-1:0]    q_wdata
);
  import bls_pkg::*;

  localparam int TW = COORD_BITS + 3;
  localparam int IW = COORD_BITS + 2;

  // stage a: differences
  logic                  a_valid_r;
  logic                  a_op_r;
  logic [COORD_BITS-1:0] a_ax_r, a_ay_r, a_bx_r, a_by_r;
  logic [COORD_BITS-1:0] a_adx_r, a_ady_r;
  logic                  a_xneg_r, a_yneg_r;

  // stage b: octant setup
  logic                  b_valid_r;
  logic                  b_op_r;
  logic [COORD_BITS-1:0] b_sx_r, b_sy_r, b_mend_r;
  logic [1:0]            b_mode_r;
  logic [TW-1:0]         b_term_r;
  logic [IW-1:0]         b_incwo_r, b_incw_r;

  logic                  b_adv, a_adv;
  logic                  x_gt, y_gt;

  logic                  xmaj, swap, mneg, rising;
  logic [COORD_BITS-1:0] maj, mabs;
  logic [TW-1:0]         maj_e, maj2_e, m2_e;
  logic [TW-1:0]         term_nxt, incwo_nxt, incw_nxt;
  logic [COORD_BITS-1:0] sx_nxt, sy_nxt, mend_nxt;
  logic [1:0]            mode_nxt;

  assign b_adv    = !b_valid_r || q_stat.can_push;
  assign a_adv    = !a_valid_r || b_adv;
  assign in_stall = !a_adv;
  assign q_push   = b_valid_r && q_stat.can_push;
  assign q_wdata  = {b_op_r, b_sx_r, b_sy_r, b_mend_r, b_mode_r,
                     b_term_r, b_incwo_r, b_incw_r};

  assign x_gt = in_start_x > in_end_x;
  assign y_gt = in_start_y > in_end_y;

  always_comb begin
    xmaj   = a_adx_r > a_ady_r;
    swap   = xmaj ? a_xneg_r : a_yneg_r;
    maj    = xmaj ? a_adx_r : a_ady_r;
    mabs   = xmaj ? a_ady_r : a_adx_r;
    mneg   = xmaj ? a_yneg_r : a_xneg_r;
    rising = (mabs != '0) && (mneg == swap);
    sx_nxt = swap ? a_bx_r : a_ax_r;
    sy_nxt = swap ? a_by_r : a_ay_r;
    if (xmaj) begin
      mend_nxt = swap ? a_ax_r : a_bx_r;
      mode_nxt = rising ? MODE_X_UP : MODE_X_DOWN;
    end else begin
      mend_nxt = swap ? a_ay_r : a_by_r;
      mode_nxt = rising ? MODE_Y_UP : MODE_Y_DOWN;
    end
    maj_e  = {3'b000, maj};
    maj2_e = {2'b00, maj, 1'b0};
    m2_e   = {2'b00, mabs, 1'b0};
    if (rising) begin
      term_nxt  = m2_e - maj_e;
      incwo_nxt = m2_e;
      incw_nxt  = m2_e - maj2_e;
    end else begin
      term_nxt  = maj_e - m2_e;
      incwo_nxt = '0 - m2_e;
      incw_nxt  = maj2_e - m2_e;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_adv) begin
        a_valid_r <= in_valid;
      end
      if (b_adv) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      a_op_r   <= in_opcode;
      a_ax_r   <= in_start_x;
      a_ay_r   <= in_start_y;
      a_bx_r   <= in_end_x;
      a_by_r   <= in_end_y;
      a_xneg_r <= x_gt;
      a_yneg_r <= y_gt;
      a_adx_r  <= x_gt ? in_start_x - in_end_x : in_end_x - in_start_x;
      a_ady_r  <= y_gt ? in_start_y - in_end_y : in_end_y - in_start_y;
    end
    if (b_adv) begin
      b_op_r    <= a_op_r;
      b_sx_r    <= sx_nxt;
      b_sy_r    <= sy_nxt;
      b_mend_r  <= mend_nxt;
      b_mode_r  <= mode_nxt;
      b_term_r  <= term_nxt;
      b_incwo_r <= incwo_nxt[IW-1:0];
      b_incw_r  <= incw_nxt[IW-1:0];
    end
  end

endmodule

// ===== rtl/bls_back.sv =====
// ----------------------------------------------------------------------------
// bls_back
// holds the line state, loads start words and steps one pixel per step word of an active line
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bls_back #(
  parameter int COORD_BITS = 12,
  parameter int ENTRY_W    = 6 * COORD_BITS + 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bls_pkg::bls_qstat_t   q_stat,
  input  logic [ENTRY_W-1:0]    q_rdata,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] out_pixel_x,
  output logic [COORD_BITS-1:0] out_pixel_y,
  output logic                  out_final_pixel
);
  import bls_pkg::*;

  localparam int TW = COORD_BITS + 3;
  localparam int IW = COORD_BITS + 2;

  logic                  e_op;
  logic [COORD_BITS-1:0] e_sx, e_sy, e_mend;
  logic [1:0]            e_mode;
  logic [TW-1:0]         e_term;
  logic [IW-1:0]         e_incwo, e_incw;

  logic                  active_r, active_nxt;
  logic [COORD_BITS-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [COORD_BITS-1:0] mend_r, mend_nxt;
  logic [1:0]            mode_r, mode_nxt;
  logic [TW-1:0]         term_r, term_nxt;
  logic [IW-1:0]         incwo_r, incwo_nxt, incw_r, incw_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [COORD_BITS-1:0] out_x_r, out_y_r;
  logic                  out_final_r;

  logic                  out_free, emit, load;
  logic                  x_major, falling, last, move;
  logic [COORD_BITS-1:0] minor, minor_step;
  logic [IW-1:0]         inc_sel;

  assign {e_op, e_sx, e_sy, e_mend, e_mode, e_term, e_incwo, e_incw} = q_rdata;

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = q_stat.has_data && (e_op == OP_START || out_free);
  assign load     = q_pop && e_op == OP_START;
  assign emit     = q_pop && e_op == OP_STEP && active_r;

  always_comb begin
    x_major    = (mode_r == MODE_X_UP) || (mode_r == MODE_X_DOWN);
    falling    = (mode_r == MODE_X_DOWN) || (mode_r == MODE_Y_DOWN);
    last       = (x_major ? cur_x_r : cur_y_r) == mend_r;
    move       = falling ? term_r[TW-1] : !term_r[TW-1];
    inc_sel    = move ? incw_r : incwo_r;
    minor      = x_major ? cur_y_r : cur_x_r;
    minor_step = falling ? minor - COORD_BITS'(1) : minor + COORD_BITS'(1);
    if (move) begin
      minor = minor_step;
    end

    active_nxt    = active_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    mend_nxt      = mend_r;
    mode_nxt      = mode_r;
    term_nxt      = term_r;
    incwo_nxt     = incwo_r;
    incw_nxt      = incw_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (load) begin
      active_nxt = 1'b1;
      cur_x_nxt  = e_sx;
      cur_y_nxt  = e_sy;
      mend_nxt   = e_mend;
      mode_nxt   = e_mode;
      term_nxt   = e_term;
      incwo_nxt  = e_incwo;
      incw_nxt   = e_incw;
    end else if (emit) begin
      out_valid_nxt = 1'b1;
      term_nxt      = term_r + {inc_sel[IW-1], inc_sel};
      if (x_major) begin
        cur_x_nxt = cur_x_r + COORD_BITS'(1);
        cur_y_nxt = minor;
      end else begin
        cur_y_nxt = cur_y_r + COORD_BITS'(1);
        cur_x_nxt = minor;
      end
      if (last) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r <= cur_x_nxt;
    cur_y_r <= cur_y_nxt;
    mend_r  <= mend_nxt;
    mode_r  <= mode_nxt;
    term_r  <= term_nxt;
    incwo_r <= incwo_nxt;
    incw_r  <= incw_nxt;
    if (emit) begin
      out_x_r     <= cur_x_r;
      out_y_r     <= cur_y_r;
      out_final_r <= last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = out_x_r;
  assign out_pixel_y     = out_y_r;
  assign out_final_pixel = out_final_r;

endmodule

// ===== rtl/bresenham_line_stepper_chk.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_stepper_chk
// port-level checks on the line stepper, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bresenham_line_stepper_assert.svh"

module bresenham_line_stepper_chk #(
  parameter int COORD_BITS = 12
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [COORD_BITS-1:0] out_pixel_x,
  input logic [COORD_BITS-1:0] out_pixel_y,
  input logic                  out_final_pixel
);

  logic [2*COORD_BITS:0] out_word;

  assign out_word = {out_pixel_x, out_pixel_y, out_final_pixel};

  // reset empties the output register
  `BLS_ASSERT_RESET(a_reset_clears, clk, !rst_n, !out_valid)

  // the input is open right after reset
  `BLS_ASSERT_RESET(a_open_after_reset, clk, !rst_n, !in_stall)

  // a word passes stage a, stage b and the queue first, so nothing comes right after reset
  `BLS_ASSERT_NEXT(a_quiet_after_reset, clk, rst_n, $rose(rst_n), !out_valid ##1 !out_valid)

  // a stalled pixel word holds
  `BLS_ASSERT_NEXT(a_hold_stalled, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_word))

endmodule

bind bresenham_line_stepper bresenham_line_stepper_chk #(
  .COORD_BITS (COORD_BITS)
) u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_pixel_x     (out_pixel_x),
  .out_pixel_y     (out_pixel_y),
  .out_final_pixel (out_final_pixel)
);

// ===== test/bresenham_line_stepper_test.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_stepper_test
// drives start and step words into the line stepper and predicts every pixel
// from its own copy of the rasterizer state; results are checked in order
// under random sender gaps and receiver stalls, a long receiver hold-off,
// directed octant, tie and extreme lines, a partly stepped full-span line
// and random lines
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bresenham_line_stepper_test;
  import bls_pkg::*;

  localparam int CW         = 12;
  localparam int COORD_MAX  = (1 << CW) - 1;
  localparam int DRAIN_PAD  = 8;
  localparam int HOLD_LEN   = 60;
  localparam int QUIET_MAX  = 2000;
  localparam int MAX_PRINTS = 100;
  localparam int LONG_STEPS = 150;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          last;
  } pixel_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic          in_opcode = OP_START;
  logic [CW-1:0] in_start_x = '0;
  logic [CW-1:0] in_start_y = '0;
  logic [CW-1:0] in_end_x = '0;
  logic [CW-1:0] in_end_y = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [CW-1:0] out_pixel_x;
  logic [CW-1:0] out_pixel_y;
  logic          out_final_pixel;

  // rasterizer state as predicted
  logic [CW-1:0]      line_x;
  logic [CW-1:0]      line_y;
  logic [CW-1:0]      line_end;
  logic signed [15:0] line_err;
  logic signed [14:0] inc_hold;
  logic signed [14:0] inc_move;
  logic [1:0]         line_mode;
  logic               line_busy;

  pixel_t pixel_q[$];
  int     words_done;
  int     pixels_seen;
  int     error_count;
  int     quiet_cycles;
  int     send_idle_pct;
  int     recv_idle_pct;
  logic   hold_trigger = 1'b0;
  logic   hold_seen = 1'b0;
  int     hold_left;

  bresenham_line_stepper #(.COORD_BITS(CW)) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_final_pixel(out_final_pixel)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTS) begin
      $display("mismatch: %s", msg);
    end
    error_count++;
  endtask

  function automatic void clear_line_state();
    line_x    = '0;
    line_y    = '0;
    line_end  = '0;
    line_err  = '0;
    inc_hold  = '0;
    inc_move  = '0;
    line_mode = MODE_X_UP;
    line_busy = 1'b0;
  endfunction

  function automatic void load_line(input int ax, input int ay, input int bx, input int by);
    int dx;
    int dy;
    int t;
    dx = bx - ax;
    dy = by - ay;
    line_busy = 1'b1;
    if (dx == 0 && dy == 0) begin
      line_x    = CW'(ax);
      line_y    = CW'(ay);
      line_end  = CW'(ax);
      line_mode = MODE_X_UP;
      line_err  = '0;
      inc_hold  = '0;
      inc_move  = '0;
      return;
    end
    if ((dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy)) begin
      if (ax > bx) begin
        t = ax; ax = bx; bx = t;
        t = ay; ay = by; by = t;
      end
      dx = bx - ax;
      dy = by - ay;
      line_end = CW'(bx);
      inc_hold = 15'(2 * dy);
      if (by > ay) begin
        line_mode = MODE_X_UP;
        line_err  = 16'(2 * dy - dx);
        inc_move  = 15'(2 * dy - 2 * dx);
      end else begin
        line_mode = MODE_X_DOWN;
        line_err  = 16'(2 * dy + dx);
        inc_move  = 15'(2 * dy + 2 * dx);
      end
    end else begin
      if (ay > by) begin
        t = ax; ax = bx; bx = t;
        t = ay; ay = by; by = t;
      end
      dx = bx - ax;
      dy = by - ay;
      line_end = CW'(by);
      inc_hold = 15'(2 * dx);
      if (bx > ax) begin
        line_mode = MODE_Y_UP;
        line_err  = 16'(2 * dx - dy);
        inc_move  = 15'(2 * dx - 2 * dy);
      end else begin
        line_mode = MODE_Y_DOWN;
        line_err  = 16'(2 * dx + dy);
        inc_move  = 15'(2 * dx + 2 * dy);
      end
    end
    line_x = CW'(ax);
    line_y = CW'(ay);
  endfunction

  function automatic void predict_word(input logic op, input logic [CW-1:0] sx,
                                       input logic [CW-1:0] sy, input logic [CW-1:0] ex,
                                       input logic [CW-1:0] ey);
    logic   x_major;
    logic   rising;
    logic   move;
    pixel_t pix;
    if (op == OP_START) begin
      load_line(sx, sy, ex, ey);
      words_done++;
      return;
    end
    if (!line_busy) begin
      return;
    end
    words_done++;
    x_major  = (line_mode == MODE_X_UP) || (line_mode == MODE_X_DOWN);
    rising   = (line_mode == MODE_X_UP) || (line_mode == MODE_Y_UP);
    pix.x    = line_x;
    pix.y    = line_y;
    pix.last = x_major ? (line_x == line_end) : (line_y == line_end);
    pixel_q  = {pixel_q, pix};
    move     = rising ? (line_err >= 0) : (line_err < 0);
    line_err = line_err + (move ? inc_move : inc_hold);
    if (x_major) begin
      if (move) begin
        line_y = rising ? line_y + 1'b1 : line_y - 1'b1;
      end
      line_x = line_x + 1'b1;
    end else begin
      if (move) begin
        line_x = rising ? line_x + 1'b1 : line_x - 1'b1;
      end
      line_y = line_y + 1'b1;
    end
    if (pix.last) begin
      line_busy = 1'b0;
    end
  endfunction

  // called right after a rising edge; returns at the edge that took the word
  task automatic send_word(input logic op, input int sx, input int sy, input int ex,
                           input int ey);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_opcode  <= op;
    in_start_x <= CW'(sx);
    in_start_y <= CW'(sy);
    in_end_x   <= CW'(ex);
    in_end_y   <= CW'(ey);
    do @(posedge clk); while (in_stall);
    predict_word(op, CW'(sx), CW'(sy), CW'(ex), CW'(ey));
  endtask

  task automatic send_steps(input int count);
    repeat (count) begin
      send_word(OP_STEP, $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                $urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
    end
  endtask

  task automatic draw_line(input int sx, input int sy, input int ex, input int ey,
                           input int extra);
    int adx;
    int ady;
    adx = ex > sx ? ex - sx : sx - ex;
    ady = ey > sy ? ey - sy : sy - ey;
    send_word(OP_START, sx, sy, ex, ey);
    send_steps((adx > ady ? adx : ady) + 1 + extra);
  endtask

  task automatic wait_for_pixels();
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  function automatic int near_coord(input int base, input int span);
    int v;
    v = base + $urandom_range(2 * span) - span;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return v;
  endfunction

  task automatic test_directed_lines();
    send_steps(1);
    draw_line(COORD_MAX, 0, COORD_MAX, 0, 0);
    draw_line(COORD_MAX, COORD_MAX, COORD_MAX - 2, COORD_MAX - 1, 0);
    draw_line(0, 2, 2, 0, 0);
    draw_line(0, COORD_MAX, 2, COORD_MAX - 1, 0);
    draw_line(1, 0, 2, 2, 0);
    send_word(OP_START, 0, 0, 3, 0);
    send_steps(1);
    draw_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX - 3, 1);
    wait_for_pixels();
  endtask

  task automatic test_long_line();
    send_word(OP_START, 0, COORD_MAX, COORD_MAX, 1000);
    send_steps(LONG_STEPS);
    wait_for_pixels();
  endtask

  task automatic test_random_lines(input int count);
    int target;
    int kind;
    int span;
    int sx;
    int sy;
    int ex;
    int ey;
    int adx;
    int ady;
    target = words_done + count;
    while (words_done < target) begin
      kind = $urandom_range(99);
      span = ($urandom_range(99) < 95) ? 12 : 120;
      sx   = $urandom_range(COORD_MAX);
      sy   = $urandom_range(COORD_MAX);
      ex   = near_coord(sx, span);
      ey   = near_coord(sy, span);
      if ($urandom_range(99) < 4) begin
        ex = sx;
        ey = sy;
      end
      if (kind < 80) begin
        draw_line(sx, sy, ex, ey, ($urandom_range(9) == 0) ? $urandom_range(1, 2) : 0);
      end else if (kind < 90) begin
        adx = ex > sx ? ex - sx : sx - ex;
        ady = ey > sy ? ey - sy : sy - ey;
        send_word(OP_START, sx, sy, ex, ey);
        send_steps($urandom_range(adx > ady ? adx : ady));
      end else begin
        send_word(1'($urandom_range(1)), $urandom_range(COORD_MAX),
                  $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                  $urandom_range(COORD_MAX));
      end
    end
    wait_for_pixels();
  endtask

  task automatic test_backpressure();
    hold_trigger <= ~hold_trigger;
    draw_line(100, 200, 148, 230, 0);
    wait_for_pixels();
  endtask

  always @(posedge clk) begin
    if (hold_trigger != hold_seen) begin
      hold_seen <= hold_trigger;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_q.size() == 0) begin
        report_mismatch($sformatf("pixel %0d (%0d,%0d) with nothing pending", pixels_seen,
                                  out_pixel_x, out_pixel_y));
      end else begin
        want = pixel_q.pop_front();
        if (out_pixel_x !== want.x) begin
          report_mismatch($sformatf("pixel %0d x got %0d want %0d", pixels_seen,
                                    out_pixel_x, want.x));
        end
        if (out_pixel_y !== want.y) begin
          report_mismatch($sformatf("pixel %0d y got %0d want %0d", pixels_seen,
                                    out_pixel_y, want.y));
        end
        if (out_final_pixel !== want.last) begin
          report_mismatch($sformatf("pixel %0d last flag got %b want %b", pixels_seen,
                                    out_final_pixel, want.last));
        end
      end
      pixels_seen++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clear_line_state();
    words_done    = 0;
    pixels_seen   = 0;
    error_count   = 0;
    quiet_cycles  = 0;
    hold_left     = 0;
    send_idle_pct = 12;
    recv_idle_pct = 73;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_lines();
    test_random_lines(280);
    test_backpressure();
    send_idle_pct = 73;
    recv_idle_pct = 12;
    test_random_lines(280);
    test_long_line();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_lines(290);
    if (pixel_q.size() != 0) begin
      report_mismatch($sformatf("%0d pixels never arrived", pixel_q.size()));
    end
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
